### rtl/sbgd_pkg.sv
// Shared types, constants and helpers for the seven-bit group decoder.
package sbgd_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [7:0] byte_type;
   typedef logic [31:0] word_type;

   // Decode mode codes
   localparam mode_type MODE_UNSIGNED = 2'd0;
   localparam mode_type MODE_ZIGZAG   = 2'd1;
   localparam mode_type MODE_PACKED   = 2'd2;

   // Byte layout
   localparam int unsigned CONT_BIT = 7;
   localparam logic [6:0] PAYLOAD_MASK = 7'h7f;

   // Group and word geometry
   localparam logic [4:0] GROUP_BITS     = 5'd7;
   localparam logic [4:0] MAX_SHIFT      = 5'd28;
   localparam logic [2:0] MAX_GROUPS     = 3'd4;
   localparam logic [3:0] WORD_THRESHOLD = 4'd9;
   localparam int unsigned WORD_BITS     = 16;

   // Zigzag decode: map the unsigned pattern back to two's complement
   function automatic word_type zigzag_decode(input word_type raw);
      word_type sign_fill;
      sign_fill = {32{raw[0]}};
      return (raw >> 1) ^ sign_fill;
   endfunction

endpackage

### rtl/seven_bit_group_decoder.sv
// Top level of the seven-bit group decoder (varint, zigzag and packed word modes).
//
//   channel  | ports                                    | direction
//   ---------+------------------------------------------+----------
//   req      | req_valid, req_ready, req_in_byte        | in
//   rsp      | rsp_valid, rsp_ready, rsp_value,         | out
//            | rsp_last, rsp_error                      |
//   csr      | csr_wr_en, csr_wr_data                   | in
//
// One byte per cycle sustained while the result side takes results; a byte
// that completes a result passes the input register, then the result register.
// The decode step is one shift-and-or between those registers, so the
// per-byte update of the accumulator sets the rate.
// Reset (synchronous, active high) clears both stages, the mode and the state.
// A stalled result holds the input register; req_ready stays high while the
// input register is empty or moves on in the same cycle.
module seven_bit_group_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   output logic        rsp_error,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   // Configuration and decode state
   sbgd_pkg::mode_type mode_ff;
   sbgd_pkg::word_type acc_ff, acc_in;
   logic [3:0]         pos_ff, pos_in;
   logic [2:0]         gc_ff, gc_in;

   // Input register
   logic               in_valid_ff;
   sbgd_pkg::byte_type in_byte_ff;

   // Result register
   logic               rsp_valid_ff;
   sbgd_pkg::word_type rsp_value_ff;
   logic               rsp_last_ff;
   logic               rsp_error_ff;

   // Decode datapath
   logic               out_free;
   logic               advance;
   logic [6:0]         payload;
   logic               more;
   logic [4:0]         shift;
   sbgd_pkg::word_type packed_acc;
   sbgd_pkg::word_type varint_acc;
   logic               emit;
   sbgd_pkg::word_type res_value;
   logic               res_last;
   logic               res_error;

   // Handshake: advance when the result register can take a new transaction
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

   // Shift-and-or for both layouts
   assign payload    = in_byte_ff[6:0] & sbgd_pkg::PAYLOAD_MASK;
   assign more       = in_byte_ff[sbgd_pkg::CONT_BIT];
   assign shift      = (gc_ff >= sbgd_pkg::MAX_GROUPS) ? sbgd_pkg::MAX_SHIFT
                                                       : 5'(5'(gc_ff) * sbgd_pkg::GROUP_BITS);
   assign packed_acc = acc_ff | (32'(payload) << pos_ff);
   assign varint_acc = acc_ff | (32'(payload) << shift);

   // Next state and result for the byte in the input register
   always_comb begin
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      gc_in     = gc_ff;
      emit      = 1'b0;
      res_value = '0;
      res_last  = 1'b0;
      res_error = 1'b0;
      if (mode_ff == sbgd_pkg::MODE_PACKED) begin
         if (pos_ff >= sbgd_pkg::WORD_THRESHOLD) begin
            // A full word is present: emit its low half, keep the rest if the run goes on
            emit      = 1'b1;
            res_value = {16'b0, packed_acc[15:0]};
            res_last  = !more;
            if (more) begin
               acc_in = packed_acc >> sbgd_pkg::WORD_BITS;
               pos_in = pos_ff - sbgd_pkg::WORD_THRESHOLD;
            end else begin
               acc_in = '0;
               pos_in = '0;
               gc_in  = '0;
            end
         end else if (!more) begin
            // Final byte with a partial word: flush it
            emit      = 1'b1;
            res_value = {16'b0, packed_acc[15:0]};
            res_last  = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            gc_in     = '0;
         end else begin
            acc_in = packed_acc;
            pos_in = pos_ff + 4'(sbgd_pkg::GROUP_BITS);
         end
      end else begin
         if (!more) begin
            // Terminating byte: emit the value, zigzag in signed mode
            emit      = 1'b1;
            res_value = (mode_ff == sbgd_pkg::MODE_ZIGZAG)
                        ? sbgd_pkg::zigzag_decode(varint_acc) : varint_acc;
            res_last  = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            gc_in     = '0;
         end else if (gc_ff >= sbgd_pkg::MAX_GROUPS) begin
            // Fifth byte still continues: drop it and flag the error
            emit      = 1'b1;
            res_last  = 1'b1;
            res_error = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            gc_in     = '0;
         end else begin
            acc_in = varint_acc;
            gc_in  = gc_ff + 3'd1;
         end
      end
   end

   // Mode register and decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sbgd_pkg::MODE_UNSIGNED;
         acc_ff  <= '0;
         pos_ff  <= '0;
         gc_ff   <= '0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
         acc_ff  <= '0;
         pos_ff  <= '0;
         gc_ff   <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         gc_ff  <= gc_in;
      end
   end

   // Input register: load on acceptance, drop once the byte advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Result register: load on emit, clear when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_ff <= res_value;
         rsp_last_ff  <= res_last;
         rsp_error_ff <= res_error;
      end
   end

   // Group count never passes the five-byte limit
   assert property (@(posedge clock) disable iff (reset)
      gc_ff <= sbgd_pkg::MAX_GROUPS)
      else $error("group count beyond limit");

   // An error result always ends the run and carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_last_ff && rsp_value_ff == '0))
      else $error("error result not last or not zero");

   // A final byte that advances always yields a last result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (advance && !more && !csr_wr_en) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final byte produced no last result");

   // Packed words never use the upper half
   assert property (@(posedge clock) disable iff (reset)
      (advance && emit && mode_ff == sbgd_pkg::MODE_PACKED) |=> (rsp_value_ff[31:16] == '0))
      else $error("packed word wider than 16 bits");

endmodule

### sim/tb_seven_bit_group_decoder.sv
// Self-checking testbench for the seven-bit group decoder in all decode modes.
module tb_seven_bit_group_decoder;

   // Spare mode code, decoded like the unsigned mode
   localparam sbgd_pkg::mode_type MODE_SPARE = 2'd3;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_BYTES = 135;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      sbgd_pkg::word_type value;
      logic               last;
      logic               error;
   } decode_result_type;

   // Track decoder state and hold the results still owed by the block
   class group_decode_scoreboard;
      sbgd_pkg::mode_type mode = sbgd_pkg::MODE_UNSIGNED;
      sbgd_pkg::word_type acc = '0;
      logic [4:0]         bit_pos = '0;
      logic [2:0]         groups = '0;
      decode_result_type  owed_results[$];
      int                 mismatches = 0;

      function void clear_state();
         acc = '0;
         bit_pos = '0;
         groups = '0;
      endfunction

      function void apply_mode(sbgd_pkg::mode_type m);
         mode = m;
         clear_state();
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Advance the decoder by one accepted byte and queue any result
      function void note_byte(sbgd_pkg::byte_type b);
         logic [6:0]         payload;
         logic               more;
         logic [4:0]         pos;
         logic [4:0]         shift;
         logic [2:0]         gc;
         sbgd_pkg::word_type sum;
         decode_result_type  r;
         payload = b[6:0];
         more = b[sbgd_pkg::CONT_BIT];
         r.error = 1'b0;
         if (mode == sbgd_pkg::MODE_PACKED) begin
            pos = {1'b0, bit_pos[3:0]};
            sum = acc | (sbgd_pkg::word_type'(payload) << pos);
            if (pos >= sbgd_pkg::WORD_THRESHOLD || !more) begin
               r.value = {16'h0, sum[15:0]};
               r.last = !more;
               owed_results.push_back(r);
            end
            if (!more)
               clear_state();
            else if (pos >= sbgd_pkg::WORD_THRESHOLD) begin
               acc = sum >> sbgd_pkg::WORD_BITS;
               bit_pos = pos - sbgd_pkg::WORD_THRESHOLD;
            end else begin
               acc = sum;
               bit_pos = pos + sbgd_pkg::GROUP_BITS;
            end
         end else begin
            gc = (groups > sbgd_pkg::MAX_GROUPS) ? sbgd_pkg::MAX_GROUPS : groups;
            shift = 5'(gc * sbgd_pkg::GROUP_BITS);
            if (shift > sbgd_pkg::MAX_SHIFT)
               shift = sbgd_pkg::MAX_SHIFT;
            sum = acc | (sbgd_pkg::word_type'(payload) << shift);
            if (!more) begin
               // undo the zigzag mapping in the signed mode
               if (mode == sbgd_pkg::MODE_ZIGZAG)
                  sum = (sum >> 1) ^ {32{sum[0]}};
               r.value = sum;
               r.last = 1'b1;
               owed_results.push_back(r);
               clear_state();
            end else if (gc >= sbgd_pkg::MAX_GROUPS) begin
               // fifth byte still continues: drop the value and flag it
               r.value = '0;
               r.last = 1'b1;
               r.error = 1'b1;
               owed_results.push_back(r);
               clear_state();
            end else begin
               acc = sum;
               groups = gc + 3'd1;
            end
         end
      endfunction

      // Compare one result transaction with the oldest owed result
      function void check_result(sbgd_pkg::word_type v, logic l, logic e);
         decode_result_type r;
         if (owed_results.size() == 0) begin
            $error("unexpected result: value %h last %b error %b", v, l, e);
            mismatches++;
            return;
         end
         r = owed_results.pop_front();
         if (v !== r.value) begin
            $error("value: expected %h, got %h", r.value, v);
            mismatches++;
         end
         if (l !== r.last) begin
            $error("last: expected %b, got %b", r.last, l);
            mismatches++;
         end
         if (e !== r.error) begin
            $error("error: expected %b, got %b", r.error, e);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [31:0] rsp_value;
   logic       rsp_last;
   logic       rsp_error;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = '0;

   logic steady = 1'b0;
   int   phase_bytes = 0;
   int   cycle_count = 0;

   group_decode_scoreboard sb = new;

   sbgd_pkg::mode_type phase_modes [PHASE_COUNT] = '{
      sbgd_pkg::MODE_UNSIGNED, sbgd_pkg::MODE_ZIGZAG, sbgd_pkg::MODE_PACKED, MODE_SPARE,
      sbgd_pkg::MODE_UNSIGNED, sbgd_pkg::MODE_PACKED, sbgd_pkg::MODE_ZIGZAG, MODE_SPARE};

   // Zero, one group, the full 32-bit value with overflow bits, unterminated run
   sbgd_pkg::byte_type unsigned_edges [12] = '{8'h00, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
                                               8'h7f, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
   // Minus one, then the largest positive value
   sbgd_pkg::byte_type zigzag_edges [6] = '{8'h01, 8'hfe, 8'hff, 8'hff, 8'hff, 8'h0f};
   // Words emitted mid-run and at the final byte, then a lone zero byte
   sbgd_pkg::byte_type packed_edges [5] = '{8'hff, 8'hff, 8'hff, 8'h7f, 8'h00};

   seven_bit_group_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last),
      .rsp_error   (rsp_error),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic bit gap_now();
      return !steady && ($urandom_range(99) < 15);
   endfunction

   // Bias payloads toward all ones and all zeros
   function automatic logic [6:0] rand_payload();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return 7'h7f;
      if (r < 25)
         return 7'h00;
      return 7'($urandom_range(127));
   endfunction

   // Stall the result side at random outside the steady phase
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 15);
   end

   // Check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_value, rsp_last, rsp_error);
   end

   // Present one byte and hold it until the transaction completes
   task automatic send_byte(input sbgd_pkg::byte_type b);
      if (gap_now()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (gap_now());
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      phase_bytes++;
   endtask

   // Drain the block, then write the mode register
   task automatic write_mode(input sbgd_pkg::mode_type m);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      sb.apply_mode(m);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_varint();
      int                 kind;
      sbgd_pkg::word_type v;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // encode a real value of random magnitude
         v = $urandom >> $urandom_range(31);
         while (v > 127) begin
            send_byte({1'b1, v[6:0]});
            v = v >> 7;
         end
         send_byte({1'b0, v[6:0]});
      end else if (kind < 80) begin
         // random groups, overlong forms included
         repeat ($urandom_range(0, 4)) send_byte({1'b1, rand_payload()});
         send_byte({1'b0, rand_payload()});
      end else if (kind < 90) begin
         // run five to seven bytes without terminating
         repeat ($urandom_range(5, 7)) send_byte({1'b1, rand_payload()});
      end else begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic send_packed_run();
      if ($urandom_range(99) < 85) begin
         repeat ($urandom_range(0, 11)) send_byte({1'b1, rand_payload()});
         send_byte({1'b0, rand_payload()});
      end else begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end
   endtask

   // Bound the run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Main stimulus: one phase per mode setting
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0)
            write_mode(phase_modes[p]);
         steady <= (p == 4);
         phase_bytes = 0;
         if (p == 0)
            foreach (unsigned_edges[i]) send_byte(unsigned_edges[i]);
         else if (p == 1)
            foreach (zigzag_edges[i]) send_byte(zigzag_edges[i]);
         else if (p == 2)
            foreach (packed_edges[i]) send_byte(packed_edges[i]);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            if (phase_modes[p] == sbgd_pkg::MODE_PACKED)
               send_packed_run();
            else
               send_varint();
         end
         // leave a partial item for the next register write, if any, to drop
         send_byte({1'b1, rand_payload()});
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
rtl/sbgd_pkg.sv
rtl/seven_bit_group_decoder.sv
sim/tb_seven_bit_group_decoder.sv
